// ----- sv/deque_with_membership_search_macros.svh -----
// Assertion macros for the deque with membership search.
// Included by the top level; depends on a clk and rst in scope.
`ifndef DEQUE_WITH_MEMBERSHIP_SEARCH_MACROS_SVH
`define DEQUE_WITH_MEMBERSHIP_SEARCH_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define DQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define DQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dqs_pkg.sv -----
// Shared types and constants for the deque with membership search.
// No dependencies; used by the controller, the datapath and the top level.
package dqs_pkg;

  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int NEW_LEN_W = 16;

  // Command codes; code 7 is unused and acts as a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH     = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_RESIZE     = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch an accepted item
    logic exec;        // apply an update that needs no scan or fill
    logic scan_first;  // issue the read of the front entry
    logic scan_step;   // compare one entry, issue the next read
    logic fill_step;   // append one zero at the back
    logic out_load;    // move the result into the output register
  } dqs_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic need_fill;
    logic hit;
    logic scan_last;
    logic fill_last;
  } dqs_sts_t;

endpackage

// ----- sv/dqs_dp.sv -----
// Datapath: entry store, front pointer, entry count, scan counter and result registers.
// Depends on dqs_pkg; driven by dqs_ctrl through dqs_ctl_t.
module dqs_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dqs_pkg::dqs_ctl_t                 ctl,
  output dqs_pkg::dqs_sts_t                 sts,
  input  logic [dqs_pkg::CMD_W-1:0]         in_cmd,
  input  logic [dqs_pkg::VALUE_W-1:0]       in_value,
  input  logic [dqs_pkg::NEW_LEN_W-1:0]     in_new_length,
  output logic                              out_found,
  output logic [$clog2(CAPACITY+1)-1:0]     out_length,
  output logic                              out_rejected
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = CW + 1;
  localparam int NLW = dqs_pkg::NEW_LEN_W;
  localparam int VW  = dqs_pkg::VALUE_W;
  localparam logic [CW-1:0]  CAP_C     = CW'(CAPACITY);
  localparam logic [SW-1:0]  CAP_S     = SW'(CAPACITY);
  localparam logic [NLW-1:0] CAP_REQ   = NLW'(CAPACITY);
  localparam logic [AW-1:0]  LAST_SLOT = AW'(CAPACITY - 1);

  logic [VW-1:0]  mem [CAPACITY];
  logic [VW-1:0]  rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [VW-1:0]  wr_data;
  logic [AW-1:0]  front;
  logic [CW-1:0]  count;
  logic [CW-1:0]  scan_idx;
  logic [CW-1:0]  req;
  dqs_pkg::cmd_t  cmd_r;
  dqs_pkg::cmd_t  in_cmd_e;
  logic [VW-1:0]  value_r;
  logic           found_r;
  logic           rej_r;
  logic           full;
  logic           empty;
  logic           sat;
  logic           rej_in;
  logic [AW-1:0]  front_dec;
  logic [AW-1:0]  front_inc;
  logic [AW-1:0]  back_slot;

  // Map an offset from a base slot into the circular store
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    begin
      sum = SW'(base) + SW'(off);
      if (sum >= CAP_S) begin
        sum = sum - CAP_S;
      end
      return sum[AW-1:0];
    end
  endfunction

  assign full      = (count == CAP_C);
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign back_slot = slot(front, count);
  assign in_cmd_e  = dqs_pkg::cmd_t'(in_cmd);
  assign sat       = (in_new_length > CAP_REQ);

  // Decide rejection from the accepted item, the current fill level and the requested length
  always_comb begin
    unique case (in_cmd_e)
      dqs_pkg::CMD_PUSH_BACK,
      dqs_pkg::CMD_PUSH_FRONT: rej_in = full;
      dqs_pkg::CMD_POP_BACK,
      dqs_pkg::CMD_POP_FRONT:  rej_in = empty;
      dqs_pkg::CMD_RESIZE:     rej_in = sat;
      default:                 rej_in = 1'b0;
    endcase
  end

  // Select the single write port: pushes and zero fill
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = back_slot;
    wr_data = value_r;
    if (ctl.exec && !full) begin
      unique case (cmd_r)
        dqs_pkg::CMD_PUSH_BACK: begin
          wr_en = 1'b1;
        end
        dqs_pkg::CMD_PUSH_FRONT: begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    if (ctl.fill_step) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end
  end

  assign rd_addr = ctl.scan_first ? front : slot(front, scan_idx);

  // Store with one write port and a registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Hold front pointer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (ctl.exec) begin
        unique case (cmd_r)
          dqs_pkg::CMD_PUSH_BACK: begin
            if (!full) count <= count + 1'b1;
          end
          dqs_pkg::CMD_PUSH_FRONT: begin
            if (!full) begin
              front <= front_dec;
              count <= count + 1'b1;
            end
          end
          dqs_pkg::CMD_POP_BACK: begin
            if (!empty) count <= count - 1'b1;
          end
          dqs_pkg::CMD_POP_FRONT: begin
            if (!empty) begin
              front <= front_inc;
              count <= count - 1'b1;
            end
          end
          dqs_pkg::CMD_RESIZE: begin
            count <= req;
          end
          dqs_pkg::CMD_CLEAR: begin
            front <= '0;
            count <= '0;
          end
          default: begin
            count <= count;
          end
        endcase
      end
      if (ctl.fill_step) begin
        count <= count + 1'b1;
      end
    end
  end

  // Latch the item, advance the scan, collect the search result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd_e;
      value_r <= in_value;
      req     <= sat ? CAP_C : in_new_length[CW-1:0];
      rej_r   <= rej_in;
      found_r <= 1'b0;
    end
    if (ctl.scan_first) begin
      scan_idx <= CW'(1);
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (sts.hit) found_r <= 1'b1;
    end
    if (ctl.out_load) begin
      out_found    <= found_r;
      out_length   <= count;
      out_rejected <= rej_r;
    end
  end

  // Report status to the controller
  assign sts.cmd       = cmd_r;
  assign sts.empty     = empty;
  assign sts.need_fill = (req > count);
  assign sts.hit       = (rd_data == value_r);
  assign sts.scan_last = (scan_idx == count);
  assign sts.fill_last = (CW'(count + 1'b1) == req);

endmodule

// ----- sv/dqs_ctrl.sv -----
// Controller: state machine sequencing decode, scan, fill and result hand-off.
// Depends on dqs_pkg; commands dqs_dp through dqs_ctl_t.
module dqs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  dqs_pkg::dqs_sts_t sts,
  output dqs_pkg::dqs_ctl_t ctl
);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    SCAN,
    FILL,
    FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Issue datapath commands for the current state
  always_comb begin
    ctl      = '0;
    ctl.load = s_tvalid && (state == IDLE);
    unique case (state)
      IDLE: begin
        ctl.exec = 1'b0;
      end
      DECODE: begin
        if (sts.cmd == dqs_pkg::CMD_SEARCH) begin
          ctl.scan_first = !sts.empty;
        end else if (!(sts.cmd == dqs_pkg::CMD_RESIZE && sts.need_fill)) begin
          ctl.exec = 1'b1;
        end
      end
      SCAN: begin
        ctl.scan_step = 1'b1;
      end
      FILL: begin
        ctl.fill_step = 1'b1;
      end
      FINISH: begin
        ctl.out_load = out_free;
      end
      default: begin
        ctl.exec = 1'b0;
      end
    endcase
  end

  // Advance state and hold output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid when the result loads, drop it once taken
      if (state == FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) state <= DECODE;
        end
        DECODE: begin
          if (sts.cmd == dqs_pkg::CMD_SEARCH && !sts.empty) begin
            state <= SCAN;
          end else if (sts.cmd == dqs_pkg::CMD_RESIZE && sts.need_fill) begin
            state <= FILL;
          end else begin
            state <= FINISH;
          end
        end
        SCAN: begin
          if (sts.hit || sts.scan_last) state <= FINISH;
        end
        FILL: begin
          if (sts.fill_last) state <= FINISH;
        end
        FINISH: begin
          if (out_free) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/deque_with_membership_search.sv -----
// Bounded deque of signed 32-bit values with membership search, one item at a time.
// Push, pop, clear, shrink and no-op go from accept through decode to the result register;
// search reads one entry per cycle and stops at a match; growth appends zeros one at a time.
// The next item is accepted the cycle after the result loads, and a result held by the
// receiver stalls the input.
// Reset clears front pointer, entry count and control, not the store; needs dqs_pkg.
`include "deque_with_membership_search_macros.svh"

module deque_with_membership_search #(
  parameter int CAPACITY = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // value [31:0], new_length [47:32]
  input  logic [47:0]                            s_tdata,
  // cmd [2:0]
  input  logic [2:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // found [0], length [LW:1], rejected [LW+1], zero padding above
  output logic [(($clog2(CAPACITY+1)+2+7)/8)*8-1:0] m_tdata
);

  localparam int LW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = LW + 2;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int VW    = dqs_pkg::VALUE_W;
  localparam int NLW   = dqs_pkg::NEW_LEN_W;

  dqs_pkg::dqs_ctl_t ctl;
  dqs_pkg::dqs_sts_t sts;
  logic              out_found;
  logic [LW-1:0]     out_length;
  logic              out_rejected;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dqs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (s_tuser),
    .in_value      (s_tdata[VW-1:0]),
    .in_new_length (s_tdata[VW+NLW-1:VW]),
    .out_found     (out_found),
    .out_length    (out_length),
    .out_rejected  (out_rejected)
  );

  // Pack the result item, zero padded to whole bytes
  assign m_tdata = OUT_TW'({out_rejected, out_length, out_found});

  `DQS_ASSERT(a_len_bound, !m_tvalid || (out_length <= LW'(CAPACITY)), "length above capacity")
  `DQS_ASSERT(a_found_rej, !(m_tvalid && out_found && out_rejected), "found and rejected together")
  `DQS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")

endmodule

// ----- tb/sv/tb_deque_with_membership_search.sv -----
// Self-checking testbench for the deque with membership search: directed corner
// cases, a long output hold-off and random command phases checked against a predictor.
// Depends on dqs_pkg and the deque_with_membership_search top level.
module tb_deque_with_membership_search;

  localparam int CAPACITY     = 64;
  localparam int LEN_W        = $clog2(CAPACITY + 1);
  localparam int RES_W        = ((LEN_W + 2 + 7) / 8) * 8;
  localparam int MAX_GAP      = 18;
  localparam int RANDOM_ITEMS = 720;
  localparam int PHASE_ITEMS  = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [dqs_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} bias_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic             rejected;
  } deque_result_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [47:0]      s_tdata  = '0;
  logic [2:0]       s_tuser  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  // Predictor state: circular store addressed from the front index
  logic [31:0] model_store [CAPACITY];
  int          model_front = 0;
  int          model_count = 0;

  deque_result_t pending_results[$];
  int  items_sent       = 0;
  int  results_seen     = 0;
  int  mismatch_count   = 0;
  int  hit_count        = 0;
  int  reject_count     = 0;
  bit  src_idle         = 1'b1;
  bit  sink_idle        = 1'b1;
  int  sink_hold_cycles = 0;
  int  sink_stall       = 0;

  deque_with_membership_search #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the predictor state and return its result
  function automatic deque_result_t predict_command(logic [2:0] cmd, logic [31:0] value,
                                                    logic [15:0] req_len);
    deque_result_t r;
    int target;
    int i;
    r = '0;
    case (cmd)
      dqs_pkg::CMD_SEARCH: begin
        for (i = 0; i < model_count; i++)
          if (model_store[(model_front + i) % CAPACITY] == value) r.found = 1'b1;
      end
      dqs_pkg::CMD_PUSH_BACK: begin
        if (model_count >= CAPACITY) begin
          r.rejected = 1'b1;
        end else begin
          model_store[(model_front + model_count) % CAPACITY] = value;
          model_count++;
        end
      end
      dqs_pkg::CMD_PUSH_FRONT: begin
        if (model_count >= CAPACITY) begin
          r.rejected = 1'b1;
        end else begin
          model_front = (model_front + CAPACITY - 1) % CAPACITY;
          model_store[model_front] = value;
          model_count++;
        end
      end
      dqs_pkg::CMD_POP_BACK: begin
        if (model_count == 0) r.rejected = 1'b1;
        else model_count--;
      end
      dqs_pkg::CMD_POP_FRONT: begin
        if (model_count == 0) begin
          r.rejected = 1'b1;
        end else begin
          model_front = (model_front + 1) % CAPACITY;
          model_count--;
        end
      end
      dqs_pkg::CMD_RESIZE: begin
        target = req_len;
        if (target > CAPACITY) begin
          target     = CAPACITY;
          r.rejected = 1'b1;
        end
        // Grow with zeros at the back; shrink drops back entries
        for (i = model_count; i < target; i++)
          model_store[(model_front + i) % CAPACITY] = '0;
        model_count = target;
      end
      dqs_pkg::CMD_CLEAR: begin
        model_count = 0;
        model_front = 0;
      end
      default: ;
    endcase
    r.length = model_count[LEN_W-1:0];
    return r;
  endfunction

  // Offer one item, after a random gap if the source idles, hold it until accepted, then predict
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] value,
                              input logic [15:0] req_len);
    int gap;
    deque_result_t exp_r;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {req_len, value};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    exp_r = predict_command(cmd, value, req_len);
    pending_results = {pending_results, exp_r};
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: random stall per item while sink_idle is set, plus a long hold-off on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sink_stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    deque_result_t got;
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.found    = m_tdata[0];
      got.length   = m_tdata[LEN_W:1];
      got.rejected = m_tdata[LEN_W+1];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result found=%0b length=%0d rejected=%0b",
                   got.found, got.length, got.rejected);
      end else begin
        want = pending_results.pop_front();
        hit_count    += want.found;
        reject_count += want.rejected;
        if (got.found !== want.found || got.length !== want.length ||
            got.rejected !== want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected %0b/%0d/%0b got %0b/%0d/%0b",
                     results_seen, want.found, want.length, want.rejected,
                     got.found, got.length, got.rejected);
        end
      end
    end
  end

  // Corner cases: empty pops, extremes, full pushes, resize edges, clear, unused code
  task automatic test_directed();
    send_command(dqs_pkg::CMD_SEARCH,     32'd0,   16'd0);
    send_command(dqs_pkg::CMD_POP_BACK,   32'd0,   16'd0);
    send_command(dqs_pkg::CMD_POP_FRONT,  32'd0,   16'd0);
    send_command(dqs_pkg::CMD_PUSH_BACK,  VAL_MAX, 16'd0);
    send_command(dqs_pkg::CMD_PUSH_FRONT, VAL_MIN, 16'hFFFF);
    send_command(dqs_pkg::CMD_SEARCH,     VAL_MIN, 16'd0);
    send_command(dqs_pkg::CMD_SEARCH,     VAL_MAX, 16'd0);
    send_command(dqs_pkg::CMD_SEARCH,     32'd0,   16'd0);
    send_command(dqs_pkg::CMD_RESIZE,     32'd0,   16'd2);
    send_command(dqs_pkg::CMD_RESIZE,     32'd0,   16'd5);
    send_command(dqs_pkg::CMD_SEARCH,     32'd0,   16'd0);
    send_command(dqs_pkg::CMD_RESIZE,     '1,      16'd1);
    send_command(dqs_pkg::CMD_SEARCH,     VAL_MAX, 16'd0);
    send_command(CMD_UNUSED,              '1,      16'hFFFF);
    send_command(dqs_pkg::CMD_RESIZE,     32'd0,   16'hFFFF);
    send_command(dqs_pkg::CMD_PUSH_BACK,  32'd7,   16'd0);
    send_command(dqs_pkg::CMD_PUSH_FRONT, 32'd9,   16'd0);
    send_command(dqs_pkg::CMD_SEARCH,     VAL_MIN, 16'd0);
    send_command(dqs_pkg::CMD_RESIZE,     32'd0,   16'(CAPACITY));
    send_command(dqs_pkg::CMD_POP_FRONT,  32'd0,   16'd0);
    send_command(dqs_pkg::CMD_POP_BACK,   32'd0,   16'd0);
    send_command(dqs_pkg::CMD_CLEAR,      '1,      16'hFFFF);
    send_command(dqs_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 16'd0);
    send_command(dqs_pkg::CMD_POP_BACK,   32'd0,   16'd0);
    send_command(dqs_pkg::CMD_RESIZE,     32'd0,   16'd0);
    wait_drain();
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int n;
    src_idle = 1'b0;
    sink_hold_cycles = HOLD_CYCLES;
    for (n = 0; n < 16; n++)
      send_command(n[0] ? dqs_pkg::CMD_SEARCH : dqs_pkg::CMD_PUSH_BACK, $urandom(),
                   16'($urandom()));
    wait_drain();
    src_idle = 1'b1;
  endtask

  // Random phases biased toward growing, shrinking or mixing, with idle on or off
  task automatic test_random();
    int          n;
    int          roll;
    int          push_w;
    int          pop_w;
    bias_t       bias;
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [15:0] req_len;
    push_w = 33;
    pop_w  = 32;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        // Pause the sender until all results are in every third phase
        if (n % (3 * PHASE_ITEMS) == 0) wait_drain();
        bias      = bias_t'($urandom_range(0, 2));
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        case (bias)
          BIAS_GROW:   begin push_w = 50; pop_w = 15; end
          BIAS_SHRINK: begin push_w = 15; pop_w = 50; end
          default:     begin push_w = 33; pop_w = 32; end
        endcase
      end

      roll = $urandom_range(0, 99);
      if (roll < 25) cmd = dqs_pkg::CMD_SEARCH;
      else if (roll < 25 + push_w)
        cmd = $urandom_range(0, 1) ? dqs_pkg::CMD_PUSH_BACK : dqs_pkg::CMD_PUSH_FRONT;
      else if (roll < 25 + push_w + pop_w)
        cmd = $urandom_range(0, 1) ? dqs_pkg::CMD_POP_BACK : dqs_pkg::CMD_POP_FRONT;
      else if (roll < 96) cmd = dqs_pkg::CMD_RESIZE;
      else if (roll < 98) cmd = dqs_pkg::CMD_CLEAR;
      else cmd = CMD_UNUSED;

      // Prefer values already stored so searches hit, then extremes, then anything
      roll = $urandom_range(0, 9);
      if (roll < 5 && model_count > 0)
        value = model_store[(model_front + $urandom_range(0, model_count - 1)) % CAPACITY];
      else if (roll < 7)
        case ($urandom_range(0, 3))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = '0;
          default: value = '1;
        endcase
      else
        value = $urandom();

      roll = $urandom_range(0, 9);
      if (cmd != dqs_pkg::CMD_RESIZE || roll == 9) req_len = 16'($urandom());
      else if (roll < 7) req_len = 16'($urandom_range(0, CAPACITY + 4));
      else req_len = (model_count < 2) ? 16'($urandom_range(0, 2))
                                       : 16'(model_count + $urandom_range(0, 4) - 2);

      send_command(cmd, value, req_len);
    end
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    // Let any stray result show up before the verdict
    repeat (CAPACITY + 8) @(posedge clk);
    $display("Summary: %0d commands sent, %0d results checked, %0d search hits, %0d rejected",
             items_sent, results_seen, hit_count, reject_count);
    $display("Covered corner cases, a long receiver hold-off and random grow/shrink phases");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20 * 400000);
    $display("TIMEOUT: %0d results still pending", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
